// ===== design/mrfc_pkg.sv =====
// Shared types and constants for the meter response frame checker.
`timescale 1ns / 1ps
package mrfc_pkg;

	localparam logic [1:0] OP_START   = 2'd0;
	localparam logic [1:0] OP_BYTE    = 2'd1;
	localparam logic [1:0] OP_TIMEOUT = 2'd2;

	localparam logic [2:0] ST_OK          = 3'd0;
	localparam logic [2:0] ST_NO_END      = 3'd1;
	localparam logic [2:0] ST_OVERSIZE    = 3'd2;
	localparam logic [2:0] ST_CRC_FAIL    = 3'd3;
	localparam logic [2:0] ST_ADDR_FAIL   = 3'd4;
	localparam logic [2:0] ST_BAD_COMMAND = 3'd5;
	localparam logic [2:0] ST_BAD_CODE    = 3'd6;

	localparam logic [1:0] CFG_DEVICE_ADDRESS     = 2'd0;
	localparam logic [1:0] CFG_EXPECTED_CODE      = 2'd1;
	localparam logic [1:0] CFG_COMMAND_ERROR_CODE = 2'd2;

	localparam logic [31:0] ERROR_VALUE = 32'hBF80_0000;
	localparam logic [15:0] CRC_INIT    = 16'hFFFF;
	localparam logic [15:0] CRC_POLY    = 16'hA001;

	localparam logic [7:0] ADDR_BYTES      = 8'd4;
	localparam logic [7:0] CODE_POS        = 8'd4;
	localparam logic [7:0] LEN_POS         = 8'd5;
	localparam logic [7:0] DATA_POS        = 8'd6;
	localparam logic [7:0] DATA_END        = 8'd10;
	localparam logic [7:0] MIN_JUDGE_COUNT = 8'd6;
	localparam logic [7:0] LAST_OFFSET     = 8'd5;

	typedef struct packed {
		logic [1:0] operation;
		logic [7:0] rx_byte;
	} item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] value_bits;
		logic [7:0]  data_last_index;
	} result_t;

	typedef struct packed {
		logic [31:0] device_address;
		logic [7:0]  expected_code;
		logic [7:0]  command_error_code;
	} cfg_t;

endpackage

// ===== design/mrfc_ifs.sv =====
// Valid/ready channel interfaces for input words and result words.
`timescale 1ns / 1ps
interface mrfc_item_if;
	logic       valid;
	logic       ready;
	logic [1:0] operation;
	logic [7:0] rx_byte;

	modport source (output valid, output operation, output rx_byte, input ready);
	modport sink (input valid, input operation, input rx_byte, output ready);
endinterface

interface mrfc_result_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [31:0] value_bits;
	logic [7:0]  data_last_index;

	modport source (output valid, output status, output value_bits, output data_last_index,
		input ready);
	modport sink (input valid, input status, input value_bits, input data_last_index,
		output ready);
endinterface

// ===== design/mrfc_crc16.sv =====
// One-byte CRC-16/MODBUS update, eight bit steps unrolled.
`timescale 1ns / 1ps
module mrfc_crc16
	import mrfc_pkg::*;
(
	input  logic [15:0] crc_in,
	input  logic [7:0]  data,
	output logic [15:0] crc_out
);

	always_comb begin
		logic [15:0] c;
		c = crc_in ^ {8'h00, data};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		crc_out = c;
	end

endmodule

// ===== design/mrfc_parser.sv =====
// Frame state registers, per-byte update and frame judgment.
`timescale 1ns / 1ps
module mrfc_parser
	import mrfc_pkg::*;
#(
	parameter int BUF_LEN = 256
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    step,
	input  item_t   item,
	input  cfg_t    cfg,
	output logic    res_valid,
	output result_t res
);

	localparam int CW = $clog2(BUF_LEN);

	logic [CW-1:0] cnt_q, cnt_nxt;
	logic [7:0]    len_q, len_nxt;
	logic [15:0]   crc0_q, crc0_nxt;
	logic [15:0]   crc1_q, crc1_nxt;
	logic [15:0]   crc2_q, crc2_nxt;
	logic [15:0]   last_q, last_nxt;
	logic          addr_ok_q, addr_ok_nxt;
	logic [7:0]    code_q, code_nxt;
	logic [31:0]   data_q, data_nxt;
	logic [2:0]    status_q, status_nxt;
	logic          rcv_q, rcv_nxt;
	logic [15:0]   crc_upd;
	logic [CW:0]   cnt_inc;
	logic [7:0]    idx8;
	logic [7:0]    cnt8;
	logic [1:0]    dsel;
	logic [2:0]    judged;

	mrfc_crc16 u_crc (
		.crc_in  (crc0_q),
		.data    (item.rx_byte),
		.crc_out (crc_upd)
	);

	always_comb begin
		cnt_nxt     = cnt_q;
		len_nxt     = len_q;
		crc0_nxt    = crc0_q;
		crc1_nxt    = crc1_q;
		crc2_nxt    = crc2_q;
		last_nxt    = last_q;
		addr_ok_nxt = addr_ok_q;
		code_nxt    = code_q;
		data_nxt    = data_q;
		status_nxt  = status_q;
		rcv_nxt     = rcv_q;
		res_valid   = 1'b0;
		res         = '0;
		idx8        = 8'(cnt_q);
		dsel        = 2'(idx8 - DATA_POS);
		cnt_inc     = (CW + 1)'(cnt_q) + (CW + 1)'(1);
		cnt8        = '0;
		judged      = ST_NO_END;

		case (item.operation)
			OP_START: begin
				cnt_nxt     = '0;
				len_nxt     = '0;
				crc0_nxt    = CRC_INIT;
				crc1_nxt    = CRC_INIT;
				crc2_nxt    = CRC_INIT;
				last_nxt    = '0;
				addr_ok_nxt = 1'b1;
				code_nxt    = '0;
				data_nxt    = '0;
				status_nxt  = ST_NO_END;
				rcv_nxt     = 1'b1;
			end
			OP_TIMEOUT: begin
				if (rcv_q) begin
					res_valid           = 1'b1;
					res.status          = status_q;
					res.value_bits      = ERROR_VALUE;
					res.data_last_index = '0;
					rcv_nxt             = 1'b0;
				end
			end
			OP_BYTE: begin
				if (rcv_q) begin
					if (idx8 < ADDR_BYTES) begin
						if (item.rx_byte != cfg.device_address[{idx8[1:0], 3'b000} +: 8]) begin
							addr_ok_nxt = 1'b0;
						end
					end else if (idx8 == CODE_POS) begin
						code_nxt = item.rx_byte;
					end else if (idx8 == LEN_POS) begin
						len_nxt = item.rx_byte;
					end else if (idx8 < DATA_END) begin
						data_nxt[{dsel, 3'b000} +: 8] = item.rx_byte;
					end
					crc2_nxt = crc1_q;
					crc1_nxt = crc0_q;
					crc0_nxt = crc_upd;
					last_nxt = {last_q[7:0], item.rx_byte};
					if (cnt_inc >= (CW + 1)'(BUF_LEN)) begin
						cnt_nxt     = '0;
						crc0_nxt    = CRC_INIT;
						crc1_nxt    = CRC_INIT;
						crc2_nxt    = CRC_INIT;
						addr_ok_nxt = 1'b1;
					end else begin
						cnt_nxt = cnt_inc[CW-1:0];
					end
					cnt8 = 8'(cnt_nxt);

					if (cnt8 <= MIN_JUDGE_COUNT || cnt8 < len_nxt) begin
						judged = ST_NO_END;
					end else if (cnt8 > len_nxt) begin
						judged = ST_OVERSIZE;
					end else if ({last_nxt[7:0], last_nxt[15:8]} != crc2_nxt) begin
						judged = ST_CRC_FAIL;
					end else if (!addr_ok_nxt) begin
						judged = ST_ADDR_FAIL;
					end else if (code_nxt != cfg.expected_code) begin
						judged = (code_nxt == cfg.command_error_code) ? ST_BAD_COMMAND
							: ST_BAD_CODE;
					end else begin
						judged = ST_OK;
					end
					status_nxt = judged;
					if (judged == ST_OK) begin
						res_valid           = 1'b1;
						res.status          = ST_OK;
						res.value_bits      = data_nxt;
						res.data_last_index = cnt8 - LAST_OFFSET;
						rcv_nxt             = 1'b0;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			len_q     <= '0;
			crc0_q    <= CRC_INIT;
			crc1_q    <= CRC_INIT;
			crc2_q    <= CRC_INIT;
			last_q    <= '0;
			addr_ok_q <= 1'b1;
			code_q    <= '0;
			data_q    <= '0;
			status_q  <= ST_NO_END;
			rcv_q     <= 1'b0;
		end else if (step) begin
			cnt_q     <= cnt_nxt;
			len_q     <= len_nxt;
			crc0_q    <= crc0_nxt;
			crc1_q    <= crc1_nxt;
			crc2_q    <= crc2_nxt;
			last_q    <= last_nxt;
			addr_ok_q <= addr_ok_nxt;
			code_q    <= code_nxt;
			data_q    <= data_nxt;
			status_q  <= status_nxt;
			rcv_q     <= rcv_nxt;
		end
	end

endmodule

// ===== design/meter_response_frame_checker.sv =====
// Top level of the meter response frame checker.
//
// Takes one word per cycle (start, received byte, timeout) and checks a reply frame
// protected by CRC-16/MODBUS. Each word passes an input register, the parse and judge
// logic (a one-byte CRC update unrolled over eight bits), and a result register, which
// holds each result until the result side takes it, and a new word can be taken every
// cycle while the result side keeps up. A good frame gives one ok result at once; a
// timeout while receiving gives the latest error.
// Configuration registers: 0 device address, 1 expected code, 2 command error code.
`timescale 1ns / 1ps
module meter_response_frame_checker
	import mrfc_pkg::*;
#(
	parameter int BUF_LEN = 256
) (
	input  logic                 clk,
	input  logic                 arst_n,
	mrfc_item_if.sink            item,
	mrfc_result_if.source        result,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [31:0]          cfg_wdata
);

	cfg_t    cfg_q;
	logic    valid_s1;
	item_t   item_s1;
	logic    advance;
	logic    fire;
	result_t res;
	logic    out_valid_q;
	result_t out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_DEVICE_ADDRESS:     cfg_q.device_address     <= cfg_wdata;
				CFG_EXPECTED_CODE:      cfg_q.expected_code      <= cfg_wdata[7:0];
				CFG_COMMAND_ERROR_CODE: cfg_q.command_error_code <= cfg_wdata[7:0];
				default: begin
				end
			endcase
		end
	end

	assign advance    = valid_s1 && (!out_valid_q || result.ready);
	assign item.ready = !valid_s1 || advance;

	// hold the accepted word until the result side can take its outcome
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1 <= '{operation: item.operation, rx_byte: item.rx_byte};
		end
	end

	mrfc_parser #(
		.BUF_LEN (BUF_LEN)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.item      (item_s1),
		.cfg       (cfg_q),
		.res_valid (fire),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && fire) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && fire) begin
			out_q <= res;
		end
	end

	assign result.valid           = out_valid_q;
	assign result.status          = out_q.status;
	assign result.value_bits      = out_q.value_bits;
	assign result.data_last_index = out_q.data_last_index;

endmodule

// ===== verif/tb.sv =====
// Testbench for the meter response frame checker: predicted reply results vs. DUT output.
`timescale 1ns / 1ps
module tb;
	import mrfc_pkg::*;

	localparam int BUF_LEN = 256;
	localparam int ITEMS_TARGET = 1400;
	localparam int TAIL_WORDS = 160;
	localparam int SETTLE_CYCLES = 4;
	localparam int HOLD_CYCLES = 200;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	typedef enum int {
		RPL_GOOD,
		RPL_BAD_CRC,
		RPL_BAD_ADDR,
		RPL_CMD_ERR,
		RPL_BAD_CODE,
		RPL_TRUNCATED,
		RPL_OVERSIZE
	} reply_kind_e;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_wdata;

	mrfc_item_if   words_in();
	mrfc_result_if results_out();

	meter_response_frame_checker #(
		.BUF_LEN(BUF_LEN)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.item(words_in),
		.result(results_out),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	logic [31:0] dev_addr;
	logic [7:0]  want_code;
	logic [7:0]  reject_code;

	logic [8:0]  rx_count;
	logic [7:0]  rx_len;
	logic [15:0] crc_all;
	logic [15:0] crc_less1;
	logic [15:0] crc_less2;
	logic [15:0] rx_tail;
	logic        addr_good;
	logic [7:0]  rx_code;
	logic [31:0] rx_data;
	logic [2:0]  rx_status;
	logic        rx_active;

	result_t pending_replies[$];
	int      error_count = 0;
	int      words_counted = 0;
	int      idle_cycles = 0;
	bit      gaps_on = 1'b1;
	bit      stalls_on = 1'b1;
	bit      hold_request = 1'b0;

	function automatic logic [15:0] crc16_modbus(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++)
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		return c;
	endfunction

	task automatic restart_frame;
		rx_count = '0;
		rx_len = '0;
		crc_all = CRC_INIT;
		crc_less1 = CRC_INIT;
		crc_less2 = CRC_INIT;
		rx_tail = '0;
		addr_good = 1'b1;
		rx_code = '0;
		rx_data = '0;
		rx_status = ST_NO_END;
	endtask

	task automatic reset_model;
		dev_addr = '0;
		want_code = '0;
		reject_code = '0;
		restart_frame();
		rx_active = 1'b0;
	endtask

	function automatic logic [2:0] frame_verdict();
		logic [15:0] sent_crc;
		if (rx_count <= MIN_JUDGE_COUNT || rx_count < rx_len)
			return ST_NO_END;
		if (rx_count > rx_len)
			return ST_OVERSIZE;
		sent_crc = {rx_tail[7:0], rx_tail[15:8]};
		if (sent_crc != crc_less2)
			return ST_CRC_FAIL;
		if (!addr_good)
			return ST_ADDR_FAIL;
		if (rx_code != want_code)
			return (rx_code == reject_code) ? ST_BAD_COMMAND : ST_BAD_CODE;
		return ST_OK;
	endfunction

	task automatic track_reply_word(input logic [1:0] op, input logic [7:0] b, output bit used);
		result_t    out;
		logic [2:0] verdict;
		int         idx;
		used = 1'b0;
		case (op)
			OP_START: begin
				restart_frame();
				rx_active = 1'b1;
				used = 1'b1;
			end
			OP_TIMEOUT: begin
				if (rx_active) begin
					out.status = rx_status;
					out.value_bits = ERROR_VALUE;
					out.data_last_index = '0;
					pending_replies.push_back(out);
					rx_active = 1'b0;
					used = 1'b1;
				end
			end
			OP_BYTE: begin
				if (rx_active) begin
					used = 1'b1;
					idx = int'(rx_count);
					if (idx < ADDR_BYTES) begin
						if (b != dev_addr[8*idx +: 8])
							addr_good = 1'b0;
					end else if (idx == CODE_POS) begin
						rx_code = b;
					end else if (idx == LEN_POS) begin
						rx_len = b;
					end else if (idx < DATA_END) begin
						rx_data[8*(idx-DATA_POS) +: 8] = b;
					end
					crc_less2 = crc_less1;
					crc_less1 = crc_all;
					crc_all = crc16_modbus(crc_all, b);
					rx_tail = {rx_tail[7:0], b};
					rx_count = rx_count + 9'd1;
					// wrap the buffer
					if (rx_count >= BUF_LEN) begin
						rx_count = '0;
						crc_all = CRC_INIT;
						crc_less1 = CRC_INIT;
						crc_less2 = CRC_INIT;
						addr_good = 1'b1;
					end
					verdict = frame_verdict();
					rx_status = verdict;
					if (verdict == ST_OK) begin
						out.status = ST_OK;
						out.value_bits = rx_data;
						out.data_last_index = rx_count[7:0] - LAST_OFFSET;
						pending_replies.push_back(out);
						rx_active = 1'b0;
					end
				end
			end
			default: begin
			end
		endcase
	endtask

	task automatic send_word(input logic [1:0] op, input logic [7:0] b);
		bit used;
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			words_in.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		words_in.valid <= 1'b1;
		words_in.operation <= op;
		words_in.rx_byte <= b;
		do @(posedge clk); while (!words_in.ready);
		track_reply_word(op, b, used);
		if (used)
			words_counted++;
	endtask

	task automatic drain_replies;
		words_in.valid <= 1'b0;
		while (pending_replies.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic load_settings(input logic [31:0] addr, input logic [7:0] code,
		input logic [7:0] reject);
		cfg_we <= 1'b1;
		cfg_index <= CFG_DEVICE_ADDRESS;
		cfg_wdata <= addr;
		@(posedge clk);
		cfg_index <= CFG_EXPECTED_CODE;
		cfg_wdata <= {24'd0, code};
		@(posedge clk);
		cfg_index <= CFG_COMMAND_ERROR_CODE;
		cfg_wdata <= {24'd0, reject};
		@(posedge clk);
		cfg_we <= 1'b0;
		dev_addr = addr;
		want_code = code;
		reject_code = reject;
	endtask

	task automatic load_random_settings;
		logic [31:0] addr;
		logic [7:0]  code;
		case ($urandom_range(0, 3))
			0: addr = '0;
			1: addr = '1;
			default: addr = $urandom;
		endcase
		code = 8'($urandom_range(0, 255));
		load_settings(addr, code,
			($urandom_range(0, 5) == 0) ? code : 8'($urandom_range(0, 255)));
	endtask

	function automatic int pick_len();
		if ($urandom_range(0, 39) == 0)
			return $urandom_range(100, 255);
		return $urandom_range(8, 20);
	endfunction

	task automatic send_reply(input reply_kind_e kind, input int len, input bit with_start,
		input bit with_timeout);
		logic [7:0]  frame[$];
		logic [15:0] crc;
		int          pos;
		for (int i = 0; i < 4; i++)
			frame.push_back(dev_addr[8*i +: 8]);
		frame.push_back(want_code);
		frame.push_back(len[7:0]);
		if (kind == RPL_BAD_ADDR) begin
			pos = $urandom_range(0, 3);
			frame[pos] = frame[pos] ^ (8'h01 << $urandom_range(0, 7));
		end
		if (kind == RPL_CMD_ERR)
			frame[CODE_POS] = reject_code;
		if (kind == RPL_BAD_CODE)
			frame[CODE_POS] = want_code ^ (8'h01 << $urandom_range(0, 7));
		while (frame.size() < len - 2)
			frame.push_back(8'($urandom_range(0, 255)));
		crc = CRC_INIT;
		foreach (frame[i])
			crc = crc16_modbus(crc, frame[i]);
		frame.push_back(crc[7:0]);
		frame.push_back(crc[15:8]);
		case (kind)
			RPL_BAD_CRC: begin
				pos = len - 1 - $urandom_range(0, 1);
				frame[pos] = frame[pos] ^ (8'h01 << $urandom_range(0, 7));
			end
			RPL_TRUNCATED: begin
				repeat ($urandom_range(1, 3)) void'(frame.pop_back());
			end
			RPL_OVERSIZE: begin
				frame[len-1] = frame[len-1] ^ 8'h80;
				repeat ($urandom_range(1, 4)) frame.push_back(8'($urandom_range(0, 255)));
			end
			default: begin
			end
		endcase
		if (with_start)
			send_word(OP_START, 8'($urandom_range(0, 255)));
		foreach (frame[i])
			send_word(OP_BYTE, frame[i]);
		if (with_timeout)
			send_word(OP_TIMEOUT, 8'($urandom_range(0, 255)));
	endtask

	task automatic send_noise(input int count);
		repeat (count) send_word(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
	endtask

	task automatic random_reply;
		reply_kind_e kind;
		int          pick;
		bit          with_timeout;
		pick = $urandom_range(0, 11);
		kind = (pick < 6) ? RPL_GOOD : reply_kind_e'(pick - 5);
		if (kind == RPL_GOOD)
			with_timeout = ($urandom_range(0, 3) == 0);
		else
			with_timeout = ($urandom_range(0, 4) != 0);
		if ($urandom_range(0, 7) == 0)
			send_noise($urandom_range(1, 4));
		send_reply(kind, pick_len(), 1'b1, with_timeout);
	endtask

	task automatic test_ignored_words;
		send_word(OP_BYTE, 8'hFF);
		send_word(OP_TIMEOUT, 8'h00);
		send_word(OP_UNUSED, 8'hA5);
		drain_replies();
	endtask

	task automatic test_directed_replies;
		load_settings(32'hFFFF_FFFF, 8'hFF, 8'h00);
		send_reply(RPL_GOOD, 8, 1'b1, 1'b0);
		send_reply(RPL_CMD_ERR, 8, 1'b1, 1'b1);
		send_word(OP_START, 8'hFF);
		send_word(OP_TIMEOUT, 8'h00);
		drain_replies();
	endtask

	task automatic test_frame_errors;
		for (int round = 0; round < 3; round++) begin
			case (round)
				0: load_settings('0, 8'h00, 8'h00);
				1: load_settings('1, 8'h00, 8'hFF);
				default: load_random_settings();
			endcase
			for (int k = RPL_GOOD; k <= RPL_OVERSIZE; k++)
				send_reply(reply_kind_e'(k), pick_len(), 1'b1, 1'b1);
			drain_replies();
		end
	endtask

	task automatic test_buffer_wrap;
		load_random_settings();
		for (int n = 0; n < 2; n++) begin
			send_word(OP_START, 8'($urandom_range(0, 255)));
			repeat (BUF_LEN + ((n == 1) ? $urandom_range(1, 3) : 0))
				send_word(OP_BYTE, 8'($urandom_range(0, 255)));
			send_reply(RPL_GOOD, 8, 1'b0, 1'b1);
		end
		send_reply(RPL_GOOD, 255, 1'b1, 1'b0);
		drain_replies();
	endtask

	task automatic test_backpressure;
		gaps_on = 1'b0;
		hold_request = 1'b1;
		repeat (6) send_reply(RPL_GOOD, 8, 1'b1, 1'b0);
		drain_replies();
		gaps_on = 1'b1;
	endtask

	task automatic test_random_traffic;
		while (words_counted < ITEMS_TARGET - TAIL_WORDS) begin
			load_random_settings();
			gaps_on = ($urandom_range(0, 3) != 0);
			stalls_on = ($urandom_range(0, 3) != 0);
			repeat (5) random_reply();
			drain_replies();
		end
		gaps_on = 1'b0;
		stalls_on = 1'b0;
		load_random_settings();
		repeat (8) random_reply();
		drain_replies();
	endtask

	initial begin
		results_out.ready <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				results_out.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (stalls_on && $urandom_range(0, 4) == 0) begin
				results_out.ready <= 1'b0;
				repeat ($urandom_range(1, 4)) @(posedge clk);
			end else begin
				results_out.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && results_out.valid && results_out.ready) begin
			if (pending_replies.size() == 0) begin
				$display("%0t: unexpected result: status %0d value %h index %0d", $time,
					results_out.status, results_out.value_bits, results_out.data_last_index);
				error_count++;
			end else begin
				want = pending_replies.pop_front();
				if (results_out.status !== want.status) begin
					$display("%0t: status mismatch: expected %0d, got %0d", $time,
						want.status, results_out.status);
					error_count++;
				end
				if (results_out.value_bits !== want.value_bits) begin
					$display("%0t: value_bits mismatch: expected %h, got %h", $time,
						want.value_bits, results_out.value_bits);
					error_count++;
				end
				if (results_out.data_last_index !== want.data_last_index) begin
					$display("%0t: data_last_index mismatch: expected %0d, got %0d", $time,
						want.data_last_index, results_out.data_last_index);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((words_in.valid && words_in.ready) || (results_out.valid && results_out.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, idle_cycles);
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		arst_n <= 1'b0;
		words_in.valid <= 1'b0;
		words_in.operation <= OP_START;
		words_in.rx_byte <= 8'h00;
		cfg_we <= 1'b0;
		cfg_index <= CFG_DEVICE_ADDRESS;
		cfg_wdata <= '0;
		reset_model();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_ignored_words();
		test_directed_replies();
		test_frame_errors();
		test_buffer_wrap();
		test_backpressure();
		test_random_traffic();
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
